/* hw/rtl/dual_queue_shared_buffer_unit_defines.svh */
// Assertion macros for the dual queue shared buffer unit.
// Used by the port checker; no other dependencies.
`ifndef DUAL_QUEUE_SHARED_BUFFER_UNIT_DEFINES_SVH
`define DUAL_QUEUE_SHARED_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define DQSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DQSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dqsb_pkg.sv */
// Package for the dual queue shared buffer unit: sizes, codes, command type.
// No dependencies.
`timescale 1ns / 1ps

package dqsb_pkg;

    localparam int DEPTH      = 16;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW         = $clog2(DEPTH + 1);
    localparam int DW         = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int FQ_AW      = $clog2(FIFO_DEPTH);
    localparam int FQ_CW      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ENQ_LOW  = 2'd0,
        OP_DEQ_LOW  = 2'd1,
        OP_ENQ_HIGH = 2'd2,
        OP_DEQ_HIGH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ENQ = 2'd0,
        ST_DEQ = 2'd1,
        ST_OVF = 2'd2,
        ST_UNF = 2'd3
    } status_t;

    typedef struct packed {
        status_t          status;
        logic             wr_en;
        logic             rd_en;
        logic [AW-1:0]    addr;
        logic [DW-1:0]    wdata;
    } cmd_t;

endpackage

/* hw/rtl/dqsb_if.sv */
// Valid/ready channel interfaces: request words in, response words out.
// Depends on dqsb_pkg for the data width.
`timescale 1ns / 1ps

interface dqsb_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [dqsb_pkg::DW-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface dqsb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic signed [dqsb_pkg::DW-1:0] data;

    modport source (output valid, output status, output data, input ready);
    modport sink   (input valid, input status, input data, output ready);
endinterface

/* hw/rtl/dqsb_front.sv */
// Front end: accepts request words, checks them against the queue pointers,
// updates the pointers and issues store commands. Depends on dqsb_pkg, dqsb_if.
`timescale 1ns / 1ps

module dqsb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    dqsb_req_if.sink             req,
    input  logic                 fifo_full,
    output logic                 push,
    output dqsb_pkg::cmd_t       cmd
);
    import dqsb_pkg::*;

    // low pointers are held plus one, so empty is zero
    logic [PW-1:0] tl1_reg, tl1_next;
    logic [PW-1:0] hl1_reg, hl1_next;
    logic [PW-1:0] th_reg, th_next;
    logic [PW-1:0] hh_reg, hh_next;
    logic [PW-1:0] hl_dec;
    logic [PW-1:0] th_dec;
    logic          ovf;

    assign req.ready = !fifo_full;
    assign push      = req.valid && !fifo_full;
    assign ovf       = (tl1_reg == th_reg);
    assign hl_dec    = hl1_reg - PW'(1);
    assign th_dec    = th_reg - PW'(1);

    always_comb
    begin
        tl1_next   = tl1_reg;
        hl1_next   = hl1_reg;
        th_next    = th_reg;
        hh_next    = hh_reg;
        cmd.status = ST_UNF;
        cmd.wr_en  = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.addr   = '0;
        cmd.wdata  = req.value;
        case (req.op)
            OP_ENQ_LOW:
            begin
                if (ovf)
                begin
                    cmd.status = ST_OVF;
                end
                else
                begin
                    if (hl1_reg == '0)
                    begin
                        hl1_next = PW'(1);
                    end
                    tl1_next   = tl1_reg + PW'(1);
                    cmd.wr_en  = 1'b1;
                    cmd.addr   = tl1_reg[AW-1:0];
                    cmd.status = ST_ENQ;
                end
            end
            OP_DEQ_LOW:
            begin
                if (hl1_reg != '0 && hl1_reg <= tl1_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.addr   = hl_dec[AW-1:0];
                    cmd.status = ST_DEQ;
                    if (hl1_reg >= tl1_reg)
                    begin
                        hl1_next = '0;
                        tl1_next = '0;
                    end
                    else
                    begin
                        hl1_next = hl1_reg + PW'(1);
                    end
                end
            end
            OP_ENQ_HIGH:
            begin
                if (ovf)
                begin
                    cmd.status = ST_OVF;
                end
                else
                begin
                    if (hh_reg == PW'(DEPTH))
                    begin
                        hh_next = PW'(DEPTH - 1);
                    end
                    th_next    = th_dec;
                    cmd.wr_en  = 1'b1;
                    cmd.addr   = th_dec[AW-1:0];
                    cmd.status = ST_ENQ;
                end
            end
            OP_DEQ_HIGH:
            begin
                if (hh_reg != PW'(DEPTH) && hh_reg >= th_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.addr   = hh_reg[AW-1:0];
                    cmd.status = ST_DEQ;
                    if (hh_reg <= th_reg)
                    begin
                        hh_next = PW'(DEPTH);
                        th_next = PW'(DEPTH);
                    end
                    else
                    begin
                        hh_next = hh_reg - PW'(1);
                    end
                end
            end
            default:
            begin
                cmd.status = ST_UNF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl1_reg <= '0;
            hl1_reg <= '0;
            th_reg  <= PW'(DEPTH);
            hh_reg  <= PW'(DEPTH);
        end
        else if (push)
        begin
            tl1_reg <= tl1_next;
            hl1_reg <= hl1_next;
            th_reg  <= th_next;
            hh_reg  <= hh_next;
        end
    end

endmodule

/* hw/rtl/dqsb_cmd_fifo.sv */
// Two-entry command queue between front end and back end.
// Depends on dqsb_pkg.
`timescale 1ns / 1ps

module dqsb_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dqsb_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output dqsb_pkg::cmd_t  pop_cmd,
    output logic            full,
    output logic            empty
);
    import dqsb_pkg::*;

    cmd_t             slot_reg [FIFO_DEPTH];
    logic [FQ_AW-1:0] wr_ptr_reg;
    logic [FQ_AW-1:0] rd_ptr_reg;
    logic [FQ_CW-1:0] count_reg;
    logic [FQ_CW-1:0] count_next;

    assign full    = (count_reg == FQ_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FQ_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FQ_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FQ_AW'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + FQ_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FQ_AW'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + FQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/dqsb_back.sv */
// Back end: carries out store commands on the shared word store and holds
// the response word until taken. Depends on dqsb_pkg, dqsb_if.
`timescale 1ns / 1ps

module dqsb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fifo_empty,
    input  dqsb_pkg::cmd_t  cmd,
    output logic            pop,
    dqsb_rsp_if.source      rsp
);
    import dqsb_pkg::*;

    logic signed [DW-1:0] mem [DEPTH];
    logic signed [DW-1:0] data_reg;
    status_t              status_reg;
    logic                 valid_reg;

    assign pop        = !fifo_empty && (!valid_reg || rsp.ready);
    assign rsp.valid  = valid_reg;
    assign rsp.status = status_reg;
    assign rsp.data   = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cmd.wr_en)
            begin
                mem[cmd.addr] <= $signed(cmd.wdata);
            end
            data_reg   <= cmd.rd_en ? mem[cmd.addr] : '0;
            status_reg <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/dual_queue_shared_buffer_unit.sv */
// Path: an accepted request word is written into the command queue, then carried out by the
// back end into the registered response word, which rsp can take once it is valid.
// Throughput: one word per cycle; req stalls only after the response register has been
// held by rsp long enough to fill the two-entry command queue, until rsp takes it.
// Reset: asynchronous, active low; both queues empty, store contents undefined.
// Depends on dqsb_pkg, dqsb_if, dqsb_front, dqsb_cmd_fifo, dqsb_back.
`timescale 1ns / 1ps

module dual_queue_shared_buffer_unit (
    input  logic        clk,
    input  logic        rst_n,
    dqsb_req_if.sink    req,
    dqsb_rsp_if.source  rsp
);
    import dqsb_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;

    dqsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (front_cmd)
    );

    dqsb_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .pop_cmd  (back_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    dqsb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .cmd        (back_cmd),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

/* hw/rtl/dqsb_checker.sv */
// Port-level checker for the dual queue shared buffer unit, bound to the top.
// Depends on dqsb_pkg and dual_queue_shared_buffer_unit_defines.svh.
`timescale 1ns / 1ps
`include "dual_queue_shared_buffer_unit_defines.svh"

module dqsb_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_ready,
    input  logic                    rsp_valid,
    input  logic                    rsp_ready,
    input  logic [1:0]              rsp_status,
    input  logic [dqsb_pkg::DW-1:0] rsp_data
);
    import dqsb_pkg::*;

    `DQSB_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data), "response word changed while stalled")
    `DQSB_ASSERT_NOW(a_data_zero, clk, rst_n, rsp_valid && rsp_status != ST_DEQ, rsp_data == '0, "nonzero data on non-dequeue response")
    `DQSB_ASSERT_NOW(a_stall_cause, clk, rst_n, !req_ready, rsp_valid && !$past(rsp_ready), "request stalled without a held response")

endmodule

bind dual_queue_shared_buffer_unit dqsb_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_data   (rsp.data)
);
